[rtl/udec_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// udec_pkg
// Shared types and constants of the UTF-8 to UTF-16 (BMP) decoder.
// ----------------------------------------------------------------------------
package udec_pkg;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [15:0] UNITS_SAT   = 16'hFFFF;
    localparam logic [15:0] MAX_UNITS_RST = 16'hFFFF;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] ASCII_TOP  = 8'h80;
    localparam logic [7:0] TERM_BYTE  = 8'h00;

    // results caused by one byte, in output order; the end item is always last
    typedef struct packed {
        logic [1:0]       n;
        logic             has_end;
        logic [2:0][15:0] unit;
        logic [2:0][15:0] cnt;
    } t_bundle;

endpackage
`default_nettype wire

[rtl/udec_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// udec byte and unit channels
// Valid/ready channels for the input bytes and the decoded code units.
// ----------------------------------------------------------------------------
interface udec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface udec_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_end;
    logic [15:0] unit_count;

    modport source (output valid, output code_unit, output is_end, output unit_count,
                    input ready);
    modport sink   (input valid, input code_unit, input is_end, input unit_count,
                    output ready);
endinterface
`default_nettype wire

[rtl/udec_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// udec_front
// Accepts one byte per cycle while the queue is not full, runs the sequence decode and queues results.
// ----------------------------------------------------------------------------
module udec_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [15:0]       i_cfg_wdata,
    udec_in_if.sink                i_in,
    input  wire logic              i_full,
    output logic                   o_push,
    output udec_pkg::t_bundle      o_bundle
);
    import udec_pkg::*;

    typedef struct packed {
        logic [7:0]       h0;
        logic [7:0]       h1;
        logic [1:0]       hc;
        logic [1:0]       skip;
        logic [15:0]      uw;
        logic             lim;
        logic [1:0]       k;
        logic [2:0][15:0] u;
        logic [2:0][15:0] c;
    } t_walk;

    logic [7:0]  r_held0, r_held1;
    logic [1:0]  r_held_cnt, r_skip;
    logic [15:0] r_units, r_max_units;
    logic        r_limit;

    logic [7:0]  n_held0, n_held1;
    logic [1:0]  n_held_cnt, n_skip;
    logic [15:0] n_units;
    logic        n_limit;

    logic        w_accept;
    t_walk       w_walk;

    function automatic logic f_is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_CODE;
    endfunction

    function automatic logic f_is_lead2(input logic [7:0] b);
        return (b & LEAD2_MASK) == LEAD2_CODE;
    endfunction

    function automatic logic f_is_lead3(input logic [7:0] b);
        return (b & LEAD3_MASK) == LEAD3_CODE;
    endfunction

    // one unit out, count saturates
    function automatic t_walk f_emit(input t_walk s, input logic [15:0] unit);
        t_walk r;
        r = s;
        if (r.uw != UNITS_SAT) r.uw = r.uw + 16'd1;
        r.u[r.k] = unit;
        r.c[r.k] = r.uw;
        r.k      = r.k + 2'd1;
        return r;
    endfunction

    // byte looked at as a new lead, nothing held and no skipping
    function automatic t_walk f_take(input t_walk s, input logic [7:0] x,
                                     input logic [15:0] maxu);
        t_walk r;
        r = s;
        if (!r.lim && (r.uw >= maxu)) r.lim = 1'b1;
        if (!r.lim) begin
            if (x < ASCII_TOP) begin
                r = f_emit(r, {8'h00, x});
            end else if (f_is_lead2(x) || f_is_lead3(x)) begin
                r.h0 = x;
                r.hc = 2'd1;
            end else begin
                r      = f_emit(r, REPL_UNIT);
                r.skip = 2'd3;
            end
        end
        return r;
    endfunction

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    always_comb begin
        t_walk      s;
        logic [7:0] b;
        logic [1:0] hc_old;
        logic       done;
        s      = '0;
        s.h0   = r_held0;
        s.h1   = r_held1;
        s.hc   = r_held_cnt;
        s.skip = r_skip;
        s.uw   = r_units;
        s.lim  = r_limit;
        b      = i_in.byte_in;
        hc_old = r_held_cnt;
        done   = 1'b0;
        if (b == TERM_BYTE) begin
            // flush held bytes, then the end item
            if (s.hc != 2'd0) begin
                s.hc = 2'd0;
                s    = f_emit(s, REPL_UNIT);
                if (hc_old == 2'd2) s = f_take(s, s.h1, r_max_units);
            end
            s.u[s.k] = 16'h0000;
            s.c[s.k] = s.uw;
            s.k      = s.k + 2'd1;
        end else if (!(s.lim && (s.hc == 2'd0))) begin
            if (s.skip != 2'd0) begin
                if (f_is_cont(b)) begin
                    s.skip = s.skip - 2'd1;
                    done   = 1'b1;
                end else begin
                    s.skip = 2'd0;
                end
            end
            if (!done) begin
                if (s.hc == 2'd0) begin
                    s = f_take(s, b, r_max_units);
                end else if (f_is_lead2(s.h0)) begin
                    s.hc = 2'd0;
                    if (f_is_cont(b)) begin
                        s = f_emit(s, {5'b0, s.h0[4:0], b[5:0]});
                    end else begin
                        s = f_emit(s, REPL_UNIT);
                        s = f_take(s, b, r_max_units);
                    end
                end else if (s.hc == 2'd1) begin
                    if (f_is_cont(b)) begin
                        s.h1 = b;
                        s.hc = 2'd2;
                    end else begin
                        s.hc = 2'd0;
                        s    = f_emit(s, REPL_UNIT);
                        s    = f_take(s, b, r_max_units);
                    end
                end else begin
                    s.hc = 2'd0;
                    if (f_is_cont(b)) begin
                        s = f_emit(s, {s.h0[3:0], s.h1[5:0], b[5:0]});
                    end else begin
                        s      = f_emit(s, REPL_UNIT);
                        s      = f_take(s, s.h1, r_max_units);
                        s.skip = 2'd0;
                        s      = f_take(s, b, r_max_units);
                    end
                end
            end
        end
        w_walk = s;
    end

    always_comb begin
        if (i_in.byte_in == TERM_BYTE) begin
            n_held0    = 8'h00;
            n_held1    = 8'h00;
            n_held_cnt = 2'd0;
            n_skip     = 2'd0;
            n_units    = 16'h0000;
            n_limit    = 1'b0;
        end else begin
            n_held0    = w_walk.h0;
            n_held1    = w_walk.h1;
            n_held_cnt = w_walk.hc;
            n_skip     = w_walk.skip;
            n_units    = w_walk.uw;
            n_limit    = w_walk.lim;
        end
    end

    assign o_push           = w_accept && (w_walk.k != 2'd0);
    assign o_bundle.n       = w_walk.k;
    assign o_bundle.has_end = (i_in.byte_in == TERM_BYTE);
    assign o_bundle.unit    = w_walk.u;
    assign o_bundle.cnt     = w_walk.c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held0     <= 8'h00;
            r_held1     <= 8'h00;
            r_held_cnt  <= 2'd0;
            r_skip      <= 2'd0;
            r_units     <= 16'h0000;
            r_limit     <= 1'b0;
            r_max_units <= MAX_UNITS_RST;
        end else begin
            if (i_cfg_we) r_max_units <= i_cfg_wdata;
            if (w_accept) begin
                r_held0    <= n_held0;
                r_held1    <= n_held1;
                r_held_cnt <= n_held_cnt;
                r_skip     <= n_skip;
                r_units    <= n_units;
                r_limit    <= n_limit;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/udec_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// udec_fifo
// Short queue of result bundles between the decode front and output back.
// ----------------------------------------------------------------------------
module udec_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire udec_pkg::t_bundle i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output udec_pkg::t_bundle      o_data
);
    import udec_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
            if (i_pop)  r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

endmodule
`default_nettype wire

[rtl/udec_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// udec_back
// Holds one bundle and hands its results out one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module udec_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire udec_pkg::t_bundle i_data,
    output logic                   o_pop,
    udec_out_if.source             o_out
);
    import udec_pkg::*;

    logic       r_valid;
    t_bundle    r_bundle;
    logic [1:0] r_idx;

    logic w_take, w_last, w_load;

    assign w_take = r_valid && o_out.ready;
    assign w_last = (r_idx == (r_bundle.n - 2'd1));
    // refill the holding slot when it is empty or as its last request leaves
    assign w_load = !i_empty && (!r_valid || (w_take && w_last));
    assign o_pop  = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (w_take) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_bundle <= i_data;
    end

    assign o_out.valid      = r_valid;
    assign o_out.code_unit  = r_bundle.unit[r_idx];
    assign o_out.unit_count = r_bundle.cnt[r_idx];
    assign o_out.is_end     = r_bundle.has_end && w_last;

endmodule
`default_nettype wire

[rtl/utf8_to_utf16_bmp_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_bmp_decoder
// Zero-terminated UTF-8 byte stream in, UTF-16 BMP code units out.
// ----------------------------------------------------------------------------
// path: the results of a byte pass through the bundle queue and then the holding
//   register of the output side before they are presented
// throughput: one byte per cycle while each byte gives at most one result and the
//   output is not stalled; the output side moves one result per cycle while
//   ready; a byte's 2 or 3 results wait in a QUEUE_DEPTH-entry bundle queue
// reset: synchronous, clears all decode state and the queue, max_units to 65535
module utf8_to_utf16_bmp_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    udec_in_if.sink          i_in,
    udec_out_if.source       o_out
);
    import udec_pkg::*;

    logic    w_push, w_full, w_pop, w_empty;
    t_bundle w_push_data, w_head;

    udec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_bundle    (w_push_data)
    );

    udec_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    udec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_data  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

[rtl/udec_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// udec_checker
// Port-level checks on the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module udec_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_code_unit,
    input wire logic        i_is_end,
    input wire logic [15:0] i_unit_count
);

    logic w_out_acc;
    assign w_out_acc = i_out_valid && i_out_ready;

    // a stalled request keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_code_unit) && $stable(i_is_end)
             && $stable(i_unit_count)))
        else $error("output request changed while stalled");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_is_end) |-> (i_code_unit == 16'h0000))
        else $error("end marker carries a nonzero code unit");

    // back to back units of one string count up by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !i_is_end && (i_unit_count != 16'hFFFF)) |=>
            (!i_out_valid || i_is_end
             || (i_unit_count == $past(i_unit_count) + 16'd1)))
        else $error("unit count did not advance by one");

    // a new string starts counting at one
    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && i_is_end) |=>
            (!i_out_valid || i_is_end || (i_unit_count == 16'd1)))
        else $error("unit count did not restart after end marker");

endmodule

bind utf8_to_utf16_bmp_decoder udec_checker u_udec_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_code_unit  (o_out.code_unit),
    .i_is_end     (o_out.is_end),
    .i_unit_count (o_out.unit_count)
);
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to UTF-16 BMP decoder. A short table of
// directed bytes is followed by random strings built mostly from well-formed
// one-, two- and three-byte sequences, with broken and invalid sequences mixed
// in. Every code unit and end marker is checked against a local decoder model
// or the table. The unit limit is changed several times while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import udec_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_TARGET  = 280;
    localparam int PHASES         = 6;
    localparam int DIR_ROWS       = 25;
    localparam int PHASE_BYTES    = (RANDOM_TARGET - DIR_ROWS) / PHASES;

    typedef struct packed {
        logic [15:0] code;
        logic        is_end;
        logic [15:0] count;
    } t_unit_rec;

    typedef struct packed {
        logic [7:0]  b;
        logic        typed;
        logic [15:0] code;
        logic        is_end;
        logic [15:0] count;
    } t_dir_row;

    // typed rows carry the one result they must give; the rest go through the model
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{8'h00, 1'b1, 16'h0000, 1'b1, 16'd0},
        '{8'h41, 1'b1, 16'h0041, 1'b0, 16'd1},
        '{8'h7F, 1'b1, 16'h007F, 1'b0, 16'd2},
        '{8'hC2, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'h80, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'hDF, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'hBF, 1'b1, 16'h07FF, 1'b0, 16'd4},
        '{8'hE0, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'h80, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'h80, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'hEF, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'hBF, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'hBF, 1'b1, 16'hFFFF, 1'b0, 16'd6},
        '{8'hF8, 1'b1, 16'hFFFD, 1'b0, 16'd7},
        '{8'hBF, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'h80, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'h41, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'hC3, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'h41, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'hE1, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'h81, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'h42, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'hE2, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'h82, 1'b0, 16'h0000, 1'b0, 16'd0},
        '{8'h00, 1'b0, 16'h0000, 1'b0, 16'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        rx_ready = 1'b0;

    udec_in_if  in_if ();
    udec_out_if out_if ();

    assign out_if.ready = rx_ready;

    utf8_to_utf16_bmp_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // decoder model state
    logic [15:0] unit_limit    = MAX_UNITS_RST;
    logic [7:0]  hold_lead     = '0;
    logic [7:0]  hold_second   = '0;
    logic [1:0]  hold_n        = '0;
    logic [1:0]  skip_n        = '0;
    logic [15:0] units_out     = '0;
    bit          stopped_flag  = 1'b0;

    t_unit_rec   pending_units [$];
    logic [7:0]  byte_plan [$];

    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int unsigned n_err = 0;
    int unsigned units_seen = 0;
    int unsigned bytes_sent = 0;
    int unsigned bytes_useful = 0;
    int unsigned strings_done = 0;
    int unsigned stall_left = 0;
    int unsigned stall_watch = 0;

    function automatic bit is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_CODE;
    endfunction

    function automatic bit is_lead2(input logic [7:0] b);
        return (b & LEAD2_MASK) == LEAD2_CODE;
    endfunction

    function automatic void put_unit(input logic [15:0] u);
        t_unit_rec r;
        if (units_out != UNITS_SAT) units_out++;
        r.code   = u;
        r.is_end = 1'b0;
        r.count  = units_out;
        pending_units.push_back(r);
    endfunction

    // byte seen as a fresh lead, nothing held and nothing to skip
    function automatic void new_lead(input logic [7:0] b);
        if (!stopped_flag && units_out >= unit_limit) stopped_flag = 1'b1;
        if (stopped_flag) return;
        if (b < ASCII_TOP) begin
            put_unit({8'h00, b});
        end else if (is_lead2(b) || (b & LEAD3_MASK) == LEAD3_CODE) begin
            hold_lead = b;
            hold_n    = 2'd1;
        end else begin
            put_unit(REPL_UNIT);
            skip_n = 2'd3;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        t_unit_rec r;
        logic [1:0] n;
        if (b == TERM_BYTE) begin
            if (hold_n != 2'd0) begin
                n      = hold_n;
                hold_n = 2'd0;
                put_unit(REPL_UNIT);
                if (n == 2'd2) new_lead(hold_second);
            end
            r.code   = 16'h0000;
            r.is_end = 1'b1;
            r.count  = units_out;
            pending_units.push_back(r);
            hold_lead    = '0;
            hold_second  = '0;
            hold_n       = '0;
            skip_n       = '0;
            units_out    = '0;
            stopped_flag = 1'b0;
            return;
        end
        if (stopped_flag && hold_n == 2'd0) return;
        if (skip_n != 2'd0) begin
            if (is_cont(b)) begin
                skip_n--;
                return;
            end
            skip_n = 2'd0;
        end
        if (hold_n == 2'd0) begin
            new_lead(b);
            return;
        end
        if (is_lead2(hold_lead)) begin
            hold_n = 2'd0;
            if (is_cont(b)) begin
                put_unit({5'b0, hold_lead[4:0], b[5:0]});
            end else begin
                put_unit(REPL_UNIT);
                new_lead(b);
            end
            return;
        end
        if (hold_n == 2'd1) begin
            if (is_cont(b)) begin
                hold_second = b;
                hold_n      = 2'd2;
            end else begin
                hold_n = 2'd0;
                put_unit(REPL_UNIT);
                new_lead(b);
            end
            return;
        end
        hold_n = 2'd0;
        if (is_cont(b)) begin
            put_unit({hold_lead[3:0], hold_second[5:0], b[5:0]});
        end else begin
            // broken three-byte form: the held continuation is retried as a lead
            put_unit(REPL_UNIT);
            new_lead(hold_second);
            skip_n = 2'd0;
            new_lead(b);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed, input t_unit_rec want);
        int unsigned n0;
        if (tx_idle && $urandom_range(0, 7) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.byte_in <= b;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        bytes_sent++;
        if (b == TERM_BYTE) strings_done++;
        if (b == TERM_BYTE || !(stopped_flag && hold_n == 2'd0)) bytes_useful++;
        n0 = pending_units.size();
        decode_byte(b);
        if (typed) begin
            while (pending_units.size() > n0) void'(pending_units.pop_back());
            pending_units.push_back(want);
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_units.size() != 0);
    endtask

    task automatic set_limit(input logic [15:0] v);
        drain();
        // a byte that gives no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        unit_limit = v;
    endtask

    // sink side stalls in bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            rx_ready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 18);
            rx_ready <= 1'b0;
        end else begin
            rx_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_unit_rec got;
        t_unit_rec want;
        if (i_rst_n && out_if.valid && rx_ready) begin
            units_seen++;
            got.code   = out_if.code_unit;
            got.is_end = out_if.is_end;
            got.count  = out_if.unit_count;
            if (pending_units.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result: unit %h end %b count %0d",
                             got.code, got.is_end, got.count);
            end else begin
                want = pending_units.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: expected unit %h end %b count %0d, got %h %b %0d",
                                 want.code, want.is_end, want.count,
                                 got.code, got.is_end, got.count);
                end
            end
        end
    end

    initial begin
        while (stall_watch < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && rx_ready))
                stall_watch = 0;
            else
                stall_watch++;
        end
        $display("timeout with %0d results outstanding", pending_units.size());
        $display("tb_top failed");
        $finish;
    end

    initial begin
        t_dir_row    row;
        t_unit_rec   want;
        logic [31:0] r;
        int unsigned lim_plan [PHASES];
        int unsigned ph_bytes;
        int unsigned term_pct;
        int unsigned k;
        int          i;
        int          ph;

        in_if.valid   <= 1'b0;
        in_if.byte_in <= 8'h00;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 16'h0000;
        i_rst_n       <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            row         = DIR_TAB[i];
            want.code   = row.code;
            want.is_end = row.is_end;
            want.count  = row.count;
            send_byte(row.b, row.typed, want);
        end

        lim_plan[0] = 0;
        lim_plan[1] = 1;
        lim_plan[2] = $urandom_range(2, 6);
        lim_plan[3] = 65535;
        lim_plan[4] = $urandom_range(7, 30);
        lim_plan[5] = 65535;

        for (ph = 0; ph < PHASES; ph++) begin
            term_pct = (ph < 3) ? 20 : 5;
            tx_idle  = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_idle  = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            // the previous string may still be open: limit changes mid-string too
            set_limit(lim_plan[ph]);
            ph_bytes = 0;
            while (ph_bytes < PHASE_BYTES) begin
                if (byte_plan.size() == 0) begin
                    if ($urandom_range(0, 99) < term_pct) begin
                        byte_plan.push_back(TERM_BYTE);
                    end else begin
                        k = $urandom_range(0, 99);
                        r = $urandom();
                        if (k < 30) begin
                            r = $urandom_range(1, 127);
                            byte_plan.push_back(r[7:0]);
                        end else if (k < 55) begin
                            byte_plan.push_back(LEAD2_CODE | {3'b000, r[4:0]});
                            byte_plan.push_back(CONT_CODE | {2'b00, r[10:5]});
                        end else if (k < 75) begin
                            byte_plan.push_back(LEAD3_CODE | {4'b0000, r[3:0]});
                            byte_plan.push_back(CONT_CODE | {2'b00, r[9:4]});
                            byte_plan.push_back(CONT_CODE | {2'b00, r[15:10]});
                        end else if (k < 82) begin
                            // lead with no continuation at all
                            byte_plan.push_back(r[16] ? (LEAD3_CODE | {4'b0000, r[3:0]})
                                                      : (LEAD2_CODE | {3'b000, r[4:0]}));
                        end else if (k < 88) begin
                            byte_plan.push_back(LEAD3_CODE | {4'b0000, r[3:0]});
                            byte_plan.push_back(CONT_CODE | {2'b00, r[9:4]});
                        end else if (k < 95) begin
                            byte_plan.push_back(LEAD3_MASK | {4'b0000, r[3:0]});
                            repeat (r[6:4] % 5)
                                byte_plan.push_back(CONT_CODE | {2'b00, 6'($urandom())});
                        end else begin
                            r = $urandom_range(1, 255);
                            byte_plan.push_back(r[7:0]);
                        end
                    end
                end
                send_byte(byte_plan.pop_front(), 1'b0, '0);
                ph_bytes++;
                if ($urandom_range(0, 199) == 0) drain();
            end
        end

        while (byte_plan.size() != 0) send_byte(byte_plan.pop_front(), 1'b0, '0);
        send_byte(TERM_BYTE, 1'b0, '0);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d bytes (%0d decoded) in %0d strings, limits %0d %0d %0d %0d %0d %0d",
                 bytes_sent, bytes_useful, strings_done, lim_plan[0], lim_plan[1],
                 lim_plan[2], lim_plan[3], lim_plan[4], lim_plan[5]);
        $display("%0d results compared, %0d errors", units_seen, n_err);
        if (n_err == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[sim.f]
rtl/udec_pkg.sv
rtl/udec_ifs.sv
rtl/udec_front.sv
rtl/udec_fifo.sv
rtl/udec_back.sv
rtl/utf8_to_utf16_bmp_decoder.sv
rtl/udec_checker.sv
tb/sv/tb_top.sv
